@@ hw/rtl/mtrr_pkg.sv @@
// ============================================================================
// mtrr_pkg - shared types and constants for the memory type resolver
// Holds operation codes, memory type codes and the command/status bundles
// exchanged between the controller and the datapath.
// ============================================================================
package mtrr_pkg;

    // Operation codes carried on the input side band
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    // Memory type codes with special resolution rules
    localparam int unsigned TYPE_W  = 3;
    localparam logic [2:0]  TYPE_UC = 3'd0;
    localparam logic [2:0]  TYPE_WT = 3'd4;
    localparam logic [2:0]  TYPE_WB = 3'd6;

    // Result transaction width (type, used_default, status, padding)
    localparam int unsigned OUT_DATA_W = 8;

    // Controller to datapath commands
    typedef struct packed {
        logic start;     // input transaction accepted this cycle
        logic scan;      // table scan in progress
        logic load_out;  // capture result into the output register
    } mtrr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done; // lookup scan finished
    } mtrr_sts_t;

endpackage

@@ hw/rtl/mtrr_ctrl.sv @@
// ============================================================================
// mtrr_ctrl - transaction sequencer for the memory type resolver
// Accepts one transaction at a time, runs the table scan for lookups and
// hands the result to the output register when it is free.
// ============================================================================
module mtrr_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             mode,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mtrr_pkg::mtrr_cmd_t    cmd,
    input  mtrr_pkg::mtrr_sts_t    sts
);
    import mtrr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   accept;
    logic   out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Issue datapath commands
    always_comb
    begin
        cmd.start    = accept;
        cmd.scan     = (state_reg == S_SCAN);
        cmd.load_out = (state_reg == S_RESP) && out_free;
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (mode == MODE_LOOKUP) ? S_SCAN : S_RESP;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the output valid until the transaction is taken
    always_comb
    begin
        priority if (cmd.load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ hw/rtl/mtrr_datapath.sv @@
// ============================================================================
// mtrr_datapath - range table and resolution logic
// Stores the ordered range table in a single-port memory, scans it one entry
// per cycle for lookups and builds the result transaction.
// ============================================================================
module mtrr_datapath
#(
    parameter int unsigned MAX_RANGES = 128,
    parameter int unsigned ADDR_BITS  = 48
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mtrr_pkg::mtrr_cmd_t           cmd,
    output mtrr_pkg::mtrr_sts_t           sts,
    input  logic [1:0]                    mode,
    input  logic [ADDR_BITS-1:0]          range_base,
    input  logic [ADDR_BITS-1:0]          range_end,
    input  logic [mtrr_pkg::TYPE_W-1:0]   entry_type,
    input  logic                          entry_fixed,
    input  logic [ADDR_BITS-1:0]          query_address,
    input  logic                          cfg_we,
    input  logic [mtrr_pkg::TYPE_W-1:0]   cfg_wdata,
    output logic [mtrr_pkg::TYPE_W-1:0]   result_type,
    output logic                          used_default,
    output logic                          status
);
    import mtrr_pkg::*;

    localparam int unsigned IDX_W  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_RANGES + 1);
    localparam int unsigned KIND_W = TYPE_W + 1;
    localparam int unsigned ENT_W  = 2 * ADDR_BITS + KIND_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RANGES);

    // Range table: {kind, end, base}, kind = {fixed, type}
    logic [ENT_W-1:0] table_mem [MAX_RANGES];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic                 rd_vld_reg;
    logic [ENT_W-1:0]     rd_ent_reg;
    logic [ADDR_BITS-1:0] query_reg;
    logic                 have_reg;
    logic                 stopped_reg;
    logic [TYPE_W-1:0]    res_reg;
    logic                 status_reg;
    logic                 lookup_reg;
    logic [TYPE_W-1:0]    default_reg;
    logic [TYPE_W-1:0]    out_type_reg;
    logic                 out_dflt_reg;
    logic                 out_status_reg;

    logic                 full;
    logic                 do_append;
    logic                 issue_go;
    logic [ADDR_BITS-1:0] rd_base;
    logic [ADDR_BITS-1:0] rd_end;
    logic [TYPE_W-1:0]    rd_type;
    logic                 rd_fixed;
    logic                 hit;
    logic                 hit_stop;
    logic                 hit_merge;

    assign full      = (count_reg == CNT_MAX);
    assign do_append = cmd.start && (mode == MODE_APPEND) && !full;
    assign issue_go  = cmd.scan && !stopped_reg && (issue_reg != count_reg);

    assign rd_base  = rd_ent_reg[ADDR_BITS-1:0];
    assign rd_end   = rd_ent_reg[2*ADDR_BITS-1:ADDR_BITS];
    assign rd_type  = rd_ent_reg[2*ADDR_BITS +: TYPE_W];
    assign rd_fixed = rd_ent_reg[ENT_W-1];

    // Classify the entry read last cycle
    assign hit       = rd_vld_reg && !stopped_reg &&
                       (query_reg >= rd_base) && (query_reg <= rd_end);
    assign hit_stop  = rd_fixed || (rd_type == TYPE_UC);
    assign hit_merge = have_reg && (((res_reg == TYPE_WB) && (rd_type == TYPE_WT)) ||
                                    ((res_reg == TYPE_WT) && (rd_type == TYPE_WB)));

    assign sts.scan_done = stopped_reg || ((issue_reg == count_reg) && !rd_vld_reg);

    // Write appended entries and read one entry per scan cycle
    always_ff @(posedge clk)
    begin
        if (do_append)
        begin
            table_mem[count_reg[IDX_W-1:0]] <= {entry_fixed, entry_type,
                                                range_end, range_base};
        end
        if (issue_go)
        begin
            rd_ent_reg <= table_mem[issue_reg[IDX_W-1:0]];
        end
    end

    // Control state: table fill, scan progress, default type
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            issue_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            have_reg    <= 1'b0;
            stopped_reg <= 1'b0;
            default_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                default_reg <= cfg_wdata;
            end
            if (cmd.start)
            begin
                issue_reg   <= '0;
                rd_vld_reg  <= 1'b0;
                have_reg    <= 1'b0;
                stopped_reg <= 1'b0;
                if (mode == MODE_CLEAR)
                begin
                    count_reg <= '0;
                end
                else if (do_append)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            else
            begin
                rd_vld_reg <= issue_go;
                if (issue_go)
                begin
                    issue_reg <= issue_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    if (!hit_merge || hit_stop)
                    begin
                        have_reg <= 1'b1;
                    end
                    if (hit_stop)
                    begin
                        stopped_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Payload: query, running result, output register
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            query_reg  <= query_address;
            lookup_reg <= (mode == MODE_LOOKUP);
            status_reg <= (mode == MODE_APPEND) && full;
            res_reg    <= '0;
        end
        else if (hit)
        begin
            priority if (hit_stop)
            begin
                res_reg <= rd_type;
            end
            else if (hit_merge)
            begin
                res_reg <= TYPE_WT;
            end
            else
            begin
                res_reg <= rd_type;
            end
        end
        if (cmd.load_out)
        begin
            out_type_reg   <= !lookup_reg ? '0 : (have_reg ? res_reg : default_reg);
            out_dflt_reg   <= lookup_reg && !have_reg;
            out_status_reg <= status_reg;
        end
    end

    assign result_type  = out_type_reg;
    assign used_default = out_dflt_reg;
    assign status       = out_status_reg;

endmodule

@@ hw/rtl/mtrr_memory_type_resolver_unit.sv @@
// ============================================================================
// mtrr_memory_type_resolver_unit - ordered memory type range resolver
// Keeps an ordered table of address ranges with memory types and resolves
// the memory type of an address with range priority and WT/WB merging.
//
//  channel   dir  handshake                  content
//  s_axis    in   s_axis_tvalid/tready       tuser: mode; tdata: range, query
//  m_axis    out  m_axis_tvalid/tready       tdata: type, used_default, status
//  cfg       in   cfg_we                     cfg_wdata: default type
//
//  Clear, append and unused modes go from accept to the result state, which
//  loads the output register once it is free. A lookup scans the N stored ranges
//  through the single table read port, one entry per cycle; a fixed or UC hit ends early.
//  One transaction is worked on at a time; the next is accepted while the
//  previous result waits in the output register.
//  rst_n clears the table fill count, the default type and the handshakes.
// ============================================================================
module mtrr_memory_type_resolver_unit
#(
    parameter int unsigned MAX_RANGES = 128,
    parameter int unsigned ADDR_BITS  = 48
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // [1:0] mode
    input  logic [1:0]                s_axis_tuser,
    // range_base, range_end, entry_type, entry_fixed, query_address, zero pad
    input  logic [((3*ADDR_BITS+mtrr_pkg::TYPE_W+1+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // [2:0] result_type, [3] used_default, [4] status, [7:5] zero
    output logic [mtrr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                      cfg_we,
    input  logic [mtrr_pkg::TYPE_W-1:0] cfg_wdata
);
    import mtrr_pkg::*;

    localparam int unsigned OFS_END   = ADDR_BITS;
    localparam int unsigned OFS_TYPE  = 2 * ADDR_BITS;
    localparam int unsigned OFS_FIXED = 2 * ADDR_BITS + TYPE_W;
    localparam int unsigned OFS_QUERY = 2 * ADDR_BITS + TYPE_W + 1;

    mtrr_cmd_t          cmd;
    mtrr_sts_t          sts;
    logic [TYPE_W-1:0]  result_type;
    logic               used_default;
    logic               status;

    // Sequence transactions
    mtrr_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .mode    (s_axis_tuser),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Store ranges and resolve lookups
    mtrr_datapath #(
        .MAX_RANGES (MAX_RANGES),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (s_axis_tuser),
        .range_base    (s_axis_tdata[ADDR_BITS-1:0]),
        .range_end     (s_axis_tdata[OFS_END +: ADDR_BITS]),
        .entry_type    (s_axis_tdata[OFS_TYPE +: TYPE_W]),
        .entry_fixed   (s_axis_tdata[OFS_FIXED]),
        .query_address (s_axis_tdata[OFS_QUERY +: ADDR_BITS]),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_type   (result_type),
        .used_default  (used_default),
        .status        (status)
    );

    // Pack the result transaction
    assign m_axis_tdata = {(OUT_DATA_W - TYPE_W - 2)'(0), status, used_default, result_type};

endmodule
